>>> rtl/bsm_pkg.sv
// bsm_pkg: shared types and constants of the bank switching memory unit
// port decode masks, control bit positions, ram-only bank layout table
// no dependencies
package bsm_pkg;

    // request kinds carried in the input tuser
    localparam logic REQ_MEM  = 1'b0;
    localparam logic REQ_PORT = 1'b1;

    // result target kinds carried in the output tuser
    typedef enum logic [1:0] {
        KIND_ROM = 2'd0,
        KIND_RAM = 2'd1,
        KIND_EXT = 2'd2
    } t_kind;

    // port decode
    localparam logic [15:0] PRI_PORT_MASK  = 16'hC002;
    localparam logic [15:0] PRI_PORT_MATCH = 16'h4000;
    localparam logic [15:0] SEC_PORT_MASK  = 16'hF002;
    localparam logic [15:0] SEC_PORT_MATCH = 16'h1000;

    // control bit positions
    localparam int PRI_SCREEN_BIT = 3;
    localparam int PRI_ROM_LO_BIT = 4;
    localparam int PRI_LOCK_BIT   = 5;
    localparam int SEC_RAMONLY_BIT = 0;
    localparam int SEC_ROM_HI_BIT = 2;
    localparam int SEC_MOTOR_BIT  = 3;
    localparam int SEC_STROBE_BIT = 4;

    // fixed banks of normal mode
    localparam logic [2:0] SLOT1_BANK = 3'd5;
    localparam logic [2:0] SLOT2_BANK = 3'd2;

    // ram-only layouts, indexed by {secondary[2:1], slot}
    localparam logic [2:0] RAM_ONLY_LAYOUT [16] = '{
        3'd0, 3'd1, 3'd2, 3'd3,
        3'd4, 3'd5, 3'd6, 3'd7,
        3'd4, 3'd5, 3'd6, 3'd3,
        3'd4, 3'd7, 3'd6, 3'd3
    };

    // paging control bytes
    typedef struct packed {
        logic [7:0] primary;
        logic [7:0] secondary;
    } t_ctrl;

endpackage

>>> rtl/bsm_ctrl_regs.sv
// bsm_ctrl_regs: primary and secondary paging control bytes with port decode
// depends on bsm_pkg
module bsm_ctrl_regs
    import bsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,        // item leaves the input register
    input  logic        i_req_type,
    input  logic [15:0] i_cpu_addr,
    input  logic [7:0]  i_write_data,
    output t_ctrl       o_ctrl,      // bytes before this item
    output t_ctrl       o_ctrl_next, // bytes after this item
    output logic        o_write_taken
);

    t_ctrl r_ctrl;
    t_ctrl n_ctrl;
    logic  pri_hit;
    logic  sec_hit;
    logic  unlocked;

    assign unlocked = ~r_ctrl.primary[PRI_LOCK_BIT];
    assign pri_hit  = (i_cpu_addr & PRI_PORT_MASK) == PRI_PORT_MATCH;
    assign sec_hit  = (i_cpu_addr & SEC_PORT_MASK) == SEC_PORT_MATCH;

    always_comb begin
        n_ctrl        = r_ctrl;
        o_write_taken = 1'b0;
        if (i_req_type == REQ_PORT && unlocked) begin
            if (pri_hit) begin
                n_ctrl.primary = i_write_data;
                o_write_taken  = 1'b1;
            end else if (sec_hit) begin
                n_ctrl.secondary = i_write_data;
                o_write_taken    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    assign o_ctrl      = r_ctrl;
    assign o_ctrl_next = n_ctrl;

    // lock is sticky until reset
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.primary[PRI_LOCK_BIT] |=> r_ctrl.primary[PRI_LOCK_BIT])
        else $error("paging lock cleared without reset");

    // locked bytes never change
    a_locked_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.primary[PRI_LOCK_BIT] |=> $stable(r_ctrl))
        else $error("control bytes changed while locked");

    // no update without an item moving on
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_ctrl))
        else $error("control bytes changed with no transaction");

endmodule

>>> rtl/bsm_xlate.sv
// bsm_xlate: address translation of a memory access to rom, ram or external
// depends on bsm_pkg
module bsm_xlate
    import bsm_pkg::*;
(
    input  logic        i_req_type,
    input  logic [15:0] i_cpu_addr,
    input  logic        i_ext_rom_disable,
    input  t_ctrl       i_ctrl,
    output t_kind       o_target_kind,
    output logic [16:0] o_phys_addr,
    output logic        o_contended
);

    logic [1:0]  slot;
    logic [13:0] offset;
    logic [2:0]  bank;
    logic [1:0]  rom_idx;

    assign slot    = i_cpu_addr[15:14];
    assign offset  = i_cpu_addr[13:0];
    assign rom_idx = {i_ctrl.secondary[SEC_ROM_HI_BIT], i_ctrl.primary[PRI_ROM_LO_BIT]};

    always_comb begin
        case (slot)
            2'd1:    bank = SLOT1_BANK;
            2'd2:    bank = SLOT2_BANK;
            2'd3:    bank = i_ctrl.primary[2:0];
            default: bank = 3'd0;
        endcase
        if (i_ctrl.secondary[SEC_RAMONLY_BIT]) begin
            bank = RAM_ONLY_LAYOUT[{i_ctrl.secondary[2:1], slot}];
        end
    end

    always_comb begin
        o_target_kind = KIND_ROM;
        o_phys_addr   = '0;
        o_contended   = 1'b0;
        if (i_req_type == REQ_MEM) begin
            if (slot == 2'd0 && i_ext_rom_disable) begin
                o_target_kind = KIND_EXT;
                o_phys_addr   = {3'd0, offset};
            end else if (!i_ctrl.secondary[SEC_RAMONLY_BIT] && slot == 2'd0) begin
                o_target_kind = KIND_ROM;
                o_phys_addr   = {1'b0, rom_idx, offset};
            end else begin
                o_target_kind = KIND_RAM;
                o_phys_addr   = {bank, offset};
                o_contended   = bank[2];
            end
        end
    end

endmodule

>>> rtl/bank_switching_mmu_two_port_unit.sv
// bank_switching_mmu_two_port_unit: top level of the two-port paging unit
// the result is registered: each transaction passes through the input register, then the result register
// throughput: one transaction per cycle while the result is taken, each register refills in the cycle it empties
// a stalled result holds off the input once both registers hold a transaction
// reset (synchronous, active low) clears both control bytes and the valid flags
// depends on bsm_pkg, bsm_ctrl_regs, bsm_xlate
module bank_switching_mmu_two_port_unit
    import bsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // cpu_addr[15:0], write_data[23:16],
                                       // ext_rom_disable[24], zero[31:25]
    input  logic        s_axis_tuser,  // req_type[0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // phys_addr[16:0], contended[17],
                                       // write_taken[18], shadow_screen[19],
                                       // disk_motor[20], printer_strobe[21],
                                       // paging_locked[22], zero[23]
    output logic [1:0]  m_axis_tuser   // target_kind[1:0]
);

    // input register
    logic        r_in_valid;
    logic        r_req_type;
    logic [15:0] r_cpu_addr;
    logic [7:0]  r_write_data;
    logic        r_ext_rom_disable;

    // result register
    logic        r_out_valid;
    logic [23:0] r_out_data;
    t_kind       r_out_kind;

    logic        advance;
    logic        out_free;
    t_ctrl       ctrl;
    t_ctrl       ctrl_next;
    logic        write_taken;
    t_kind       target_kind;
    logic [16:0] phys_addr;
    logic        contended;
    logic [23:0] n_out_data;

    // result register frees up when empty or taken this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    // input register refills whenever its item moves on
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cpu_addr        <= s_axis_tdata[15:0];
            r_write_data      <= s_axis_tdata[23:16];
            r_ext_rom_disable <= s_axis_tdata[24];
            r_req_type        <= s_axis_tuser;
        end
    end

    // control bytes update as the item passes into the result register
    bsm_ctrl_regs u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_req_type    (r_req_type),
        .i_cpu_addr    (r_cpu_addr),
        .i_write_data  (r_write_data),
        .o_ctrl        (ctrl),
        .o_ctrl_next   (ctrl_next),
        .o_write_taken (write_taken)
    );

    // translation sees the bytes as they stood before this item
    bsm_xlate u_xlate (
        .i_req_type        (r_req_type),
        .i_cpu_addr        (r_cpu_addr),
        .i_ext_rom_disable (r_ext_rom_disable),
        .i_ctrl            (ctrl),
        .o_target_kind     (target_kind),
        .o_phys_addr       (phys_addr),
        .o_contended       (contended)
    );

    // status bits show the bytes after a port write
    assign n_out_data = {1'b0,
                         ctrl_next.primary[PRI_LOCK_BIT],
                         ctrl_next.secondary[SEC_STROBE_BIT],
                         ctrl_next.secondary[SEC_MOTOR_BIT],
                         ctrl_next.primary[PRI_SCREEN_BIT],
                         write_taken,
                         contended,
                         phys_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
            r_out_kind <= target_kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    // a port write result carries no translation
    a_write_no_xlate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[18]) |->
        (r_out_kind == KIND_ROM && r_out_data[17:0] == 18'd0))
        else $error("port write result carries a translation");

    // a stalled result is never overwritten by the next item
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !advance)
        else $error("result overwritten while stalled");

    // contention only on internal ram
    a_contended_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[17]) |-> r_out_kind == KIND_RAM)
        else $error("contended flag on non-ram access");

endmodule
